### rtl/fpr_pkg.sv
// ---------------------------------------------------------------------------
// fpr_pkg: shared types and codes of the FIFO page replacement unit
// Outcome codes and the sequencer state type.
// ---------------------------------------------------------------------------
`default_nettype none
package fpr_pkg;
  typedef enum logic [1:0] {
    OUT_HIT     = 2'd0,
    OUT_FREE    = 2'd1,
    OUT_EVICT   = 2'd2,
    OUT_RELEASE = 2'd3
  } outcome_t;

  typedef enum logic {
    OP_ACCESS  = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,    // zero page table and frame bitmap after reset
    S_IDLE,
    S_LOOK,     // read page entry
    S_LOOK2,    // registered entry available
    S_SCAN,     // free-frame search: read occupancy of candidate
    S_SCAN2,    // free-frame search: test candidate
    S_EVICT,    // read owner and next link of head
    S_EVICT2,
    S_FILL,     // write new page, owner, append
    S_REL,      // walk page entries of a process
    S_REL2,
    S_UNLINK,   // unlink a frame: links read
    S_UNLINK2,
    S_DONE
  } state_t;
endpackage
`default_nettype wire

### rtl/fifo_page_replacement_unit.sv
// Steps: a hit reads the page entry; a fault into a free frame runs the
// next-fit search over the frames; an eviction examines every frame, then
// unlinks and refills the head; a release walks the page entries of the
// process and unlinks each frame held. One item at a time: input ready only
// when idle, in the cycle after the result transfer. After synchronous reset a
// clearing pass holds input off.
// ---------------------------------------------------------------------------
// fifo_page_replacement_unit
// Per-process page tables, frame bitmap and load-order list with a sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module fifo_page_replacement_unit #(
  parameter int PROCESSES = 16,
  parameter int PAGES     = 32,
  parameter int FRAMES    = 256
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       op,
  input  wire logic [3:0] process,
  input  wire logic [4:0] page,
  input  wire logic       is_write,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      outcome
);
  import fpr_pkg::*;

  localparam int ENTRIES = PROCESSES * PAGES;
  localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int FW = $clog2(FRAMES);
  localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int QW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
  localparam int CW = FW + 1;
  localparam int TW = FW + 2;   // page table word: valid, dirty, frame
  localparam int CLRN = (ENTRIES > FRAMES) ? ENTRIES : FRAMES;
  localparam int KW = $clog2(CLRN);
  localparam logic [FW-1:0] FLAST = FW'(FRAMES - 1);

  state_t state, state_next;

  // memories
  logic [TW-1:0] page_table [ENTRIES];
  logic          frame_used [FRAMES];
  logic [FW-1:0] order_next [FRAMES];
  logic [FW-1:0] order_prev [FRAMES];
  logic [EW-1:0] frame_owner [FRAMES];

  logic [FW-1:0] alloc_pointer, order_head, order_tail;
  logic [CW-1:0] order_count;

  logic          r_w;
  logic [QW-1:0] r_proc;
  logic [PW-1:0] r_page;
  logic [EW-1:0] r_entry;
  logic [FW-1:0] cand;      // frame under search
  logic [CW-1:0] tries;
  logic [FW-1:0] vict;      // frame being unlinked / evicted
  logic          from_rel;
  logic [KW-1:0] clr_idx;
  logic [TW-1:0] pt_rd;
  logic          used_rd;
  logic [FW-1:0] rd_next, rd_prev;
  logic [EW-1:0] rd_owner;
  logic [1:0]    res;

  logic          pt_we, fu_we, fu_wdata;
  logic [EW-1:0] pt_waddr;
  logic [TW-1:0] pt_wdata;
  logic [FW-1:0] fu_waddr;

  // index reduction as small constant tables
  logic [QW-1:0] proc_mod [16];
  logic [PW-1:0] page_mod [32];
  for (genvar g = 0; g < 16; g++) begin : g_proc_mod
    assign proc_mod[g] = QW'(g % PROCESSES);
  end
  for (genvar g = 0; g < 32; g++) begin : g_page_mod
    assign page_mod[g] = PW'(g % PAGES);
  end

  logic [QW-1:0] proc_m;
  logic [PW-1:0] page_m;
  always_comb begin
    proc_m = proc_mod[process];
    page_m = page_mod[page];
  end

  logic [FW-1:0] cand_inc;
  assign cand_inc = (cand == FLAST) ? '0 : cand + 1'b1;

  assign in_ready = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_idx == KW'(CLRN - 1)) state_next = S_IDLE;
      S_IDLE:  if (in_valid) state_next = (op == OP_RELEASE) ? S_REL : S_LOOK;
      S_LOOK:  state_next = S_LOOK2;
      S_LOOK2: state_next = pt_rd[TW-1] ? S_DONE : S_SCAN;
      S_SCAN:  state_next = S_SCAN2;
      S_SCAN2: begin
        if (!used_rd) state_next = S_FILL;
        else if (tries == CW'(FRAMES - 1))
          state_next = (order_count == '0) ? S_DONE : S_EVICT;
        else state_next = S_SCAN;
      end
      S_EVICT:  state_next = S_EVICT2;
      S_EVICT2: state_next = S_UNLINK2;
      S_FILL:   state_next = S_DONE;
      S_REL:    state_next = S_REL2;
      S_REL2: begin
        // a valid page always holds a used frame
        if (pt_rd[TW-1]) state_next = S_UNLINK;
        else if (r_page == PW'(PAGES - 1)) state_next = S_DONE;
        else state_next = S_REL;
      end
      S_UNLINK:  state_next = S_UNLINK2;
      S_UNLINK2: begin
        if (!from_rel) state_next = S_FILL;
        else if (r_page == PW'(PAGES - 1)) state_next = S_DONE;
        else state_next = S_REL;
      end
      S_DONE: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign out_valid = (state == S_DONE);
  assign outcome   = res;

  // write ports of page table and frame bitmap
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = r_entry;
    pt_wdata = '0;
    fu_we    = 1'b0;
    fu_waddr = vict;
    fu_wdata = 1'b0;
    case (state)
      S_CLEAR: begin
        pt_we    = (32'(clr_idx) < ENTRIES);
        pt_waddr = EW'(clr_idx);
        fu_we    = (32'(clr_idx) < FRAMES);
        fu_waddr = FW'(clr_idx);
      end
      S_LOOK2: begin
        pt_we    = pt_rd[TW-1] && r_w;
        pt_wdata = {2'b11, pt_rd[FW-1:0]};
      end
      S_EVICT2: begin
        pt_we    = 1'b1;
        pt_waddr = rd_owner;
      end
      S_FILL: begin
        pt_we    = 1'b1;
        pt_wdata = {1'b1, r_w, vict};
        fu_we    = 1'b1;
        fu_wdata = 1'b1;
      end
      S_REL2: begin
        pt_we    = 1'b1;
        fu_we    = pt_rd[TW-1];
        fu_waddr = pt_rd[FW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) page_table[pt_waddr] <= pt_wdata;
    pt_rd <= page_table[r_entry];
  end

  always_ff @(posedge clk) begin
    if (fu_we) frame_used[fu_waddr] <= fu_wdata;
    used_rd <= frame_used[cand];
  end

  // link memory reads, registered
  always_ff @(posedge clk) begin
    rd_next  <= order_next[vict];
    rd_prev  <= order_prev[vict];
    rd_owner <= frame_owner[vict];
  end

  // link memory writes
  always_ff @(posedge clk) begin
    if (state == S_FILL) begin
      frame_owner[vict] <= r_entry;
      if (order_count != '0) begin
        order_next[order_tail] <= vict;
        order_prev[vict]       <= order_tail;
      end
    end
    if (state == S_UNLINK2 && order_count > CW'(1) &&
        vict != order_head && vict != order_tail) begin
      order_next[rd_prev] <= rd_next;
      order_prev[rd_next] <= rd_prev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      alloc_pointer <= FLAST;
      order_head <= '0;
      order_tail <= '0;
      order_count <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_CLEAR: clr_idx <= clr_idx + 1'b1;
        S_IDLE: if (in_valid) begin
          r_w <= is_write; r_proc <= proc_m;
          r_page <= (op == OP_RELEASE) ? '0 : page_m;
          r_entry <= EW'(32'(proc_m) * PAGES +
                         ((op == OP_RELEASE) ? 0 : 32'(page_m)));
          res <= (op == OP_RELEASE) ? OUT_RELEASE : OUT_HIT;
        end
        S_LOOK2: begin
          cand <= (alloc_pointer == FLAST) ? '0 : alloc_pointer + 1'b1;
          tries <= '0;
        end
        S_SCAN2: begin
          if (!used_rd) begin
            vict <= cand; alloc_pointer <= cand; res <= OUT_FREE;
            from_rel <= 1'b0;
          end else begin
            cand <= cand_inc;
            tries <= tries + 1'b1;
            if (tries == CW'(FRAMES - 1)) begin
              res <= OUT_EVICT; vict <= order_head; from_rel <= 1'b0;
            end
          end
        end
        S_FILL: begin
          if (order_count == '0) order_head <= vict;
          order_tail <= vict;
          order_count <= order_count + 1'b1;
        end
        S_REL2: begin
          if (pt_rd[TW-1]) begin
            vict <= pt_rd[FW-1:0]; from_rel <= 1'b1;
          end else if (r_page != PW'(PAGES - 1)) begin
            r_page <= r_page + 1'b1; r_entry <= r_entry + 1'b1;
          end
        end
        S_UNLINK2: begin
          if (order_count != '0) begin
            if (order_count == CW'(1)) begin
              order_head <= '0; order_tail <= '0;
            end else if (vict == order_head) order_head <= rd_next;
            else if (vict == order_tail) order_tail <= rd_prev;
            order_count <= order_count - 1'b1;
          end
          if (from_rel && r_page != PW'(PAGES - 1)) begin
            r_page <= r_page + 1'b1; r_entry <= r_entry + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while result pending");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    order_count <= CW'(FRAMES)) else $error("list count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(outcome))
    else $error("result dropped");
endmodule
`default_nettype wire
